// File: rtl/index_vertex_range_scan_assert.svh
`ifndef INDEX_VERTEX_RANGE_SCAN_ASSERT_SVH
`define INDEX_VERTEX_RANGE_SCAN_ASSERT_SVH

// Checks that hold in the same cycle and checks that hold in the cycle after.
`ifndef NO_ASSERTIONS
`define IVRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("index_vertex_range_scan check failed");
`define IVRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("index_vertex_range_scan check failed");
`else
`define IVRS_ASSERT_NOW(label, ante, cons)
`define IVRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/ivrs_pkg.sv
package ivrs_pkg;

	localparam int DATA_W    = 32;
	localparam int SHORT_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_VERTEX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] min_index;
		logic [DATA_W-1:0] max_index;
		logic [DATA_W-1:0] first_vertex;
		logic [DATA_W-1:0] last_vertex;
		logic              out_of_range;
	} scan_state_t;

	localparam scan_state_t SCAN_CLEAR = '{
		min_index:    '1,
		max_index:    '0,
		first_vertex: '1,
		last_vertex:  '0,
		out_of_range: 1'b0
	};

endpackage

// File: rtl/index_vertex_range_scan.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// index    | idx_valid, idx_stall | index_value, last_index
// result   | res_valid, res_stall | range_valid, first_vertex, vertex_count,
//          |                      | min_index, max_index
// config   | cfg_write_en         | cfg_index, cfg_data
//
// One index is taken per cycle while idx_stall is low. An index is registered,
// and when it moves on, the running minima and maxima are updated; on the last
// index of a draw the result register is loaded from the updated values and
// the running state is cleared instead. Reset sets the registers to 16-bit
// indices, zero base and zero capacity, and clears the running state. A
// stalled result holds back only a registered last index, and the index input
// stalls behind it; other indices move on regardless.
`include "index_vertex_range_scan_assert.svh"

module index_vertex_range_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         idx_valid,
	output logic                         idx_stall,
	input  logic [ivrs_pkg::DATA_W-1:0]  index_value,
	input  logic                         last_index,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         range_valid,
	output logic [ivrs_pkg::DATA_W-1:0]  first_vertex,
	output logic [ivrs_pkg::DATA_W-1:0]  vertex_count,
	output logic [ivrs_pkg::DATA_W-1:0]  min_index,
	output logic [ivrs_pkg::DATA_W-1:0]  max_index,
	input  logic                         cfg_write_en,
	input  logic [ivrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ivrs_pkg::DATA_W-1:0]  cfg_data
);
	import ivrs_pkg::*;

	logic              short_mode_q;
	logic [DATA_W-1:0] base_vertex_q;
	logic [DATA_W-1:0] capacity_q;

	logic              valid_s1;
	logic [DATA_W-1:0] index_s1;
	logic              last_s1;

	scan_state_t       run_q;
	scan_state_t       run_nxt;

	logic              res_valid_q;
	logic              range_valid_q;
	logic [DATA_W-1:0] first_vertex_q;
	logic [DATA_W-1:0] vertex_count_q;
	logic [DATA_W-1:0] min_index_q;
	logic [DATA_W-1:0] max_index_q;

	logic              advance;
	logic [DATA_W-1:0] index_m;
	logic [DATA_W+1:0] vertex_sum;
	logic [DATA_W-1:0] vertex;
	logic              in_range;
	logic              draw_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_mode_q  <= 1'b1;
			base_vertex_q <= '0;
			capacity_q    <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_SHORT_MODE:  short_mode_q  <= cfg_data[0];
				CFG_BASE_VERTEX: base_vertex_q <= cfg_data;
				CFG_CAPACITY:    capacity_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A registered last index may only move on when the result register is free.
	assign advance   = valid_s1 && (!last_s1 || !res_valid_q || !res_stall);
	assign idx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (idx_valid && !idx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (idx_valid && !idx_stall) begin
			index_s1 <= index_value;
			last_s1  <= last_index;
		end
	end

	always_comb begin
		index_m = short_mode_q ? {{(DATA_W-SHORT_W){1'b0}}, index_s1[SHORT_W-1:0]} : index_s1;
		vertex_sum = {2'b00, index_m} + {{2{base_vertex_q[DATA_W-1]}}, base_vertex_q};
		vertex   = vertex_sum[DATA_W-1:0];
		in_range = !vertex_sum[DATA_W+1] && !vertex_sum[DATA_W] && (vertex < capacity_q);

		run_nxt = run_q;
		if (in_range) begin
			if (index_m < run_q.min_index)   run_nxt.min_index    = index_m;
			if (index_m > run_q.max_index)   run_nxt.max_index    = index_m;
			if (vertex < run_q.first_vertex) run_nxt.first_vertex = vertex;
			if (vertex > run_q.last_vertex)  run_nxt.last_vertex  = vertex;
		end else begin
			run_nxt.out_of_range = 1'b1;
		end

		draw_ok = !run_nxt.out_of_range && (capacity_q != '0) &&
			(run_nxt.last_vertex >= run_nxt.first_vertex);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= SCAN_CLEAR;
		end else if (advance) begin
			run_q <= last_s1 ? SCAN_CLEAR : run_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			range_valid_q  <= draw_ok;
			first_vertex_q <= draw_ok ? run_nxt.first_vertex : '0;
			vertex_count_q <= draw_ok ? (run_nxt.last_vertex - run_nxt.first_vertex +
				DATA_W'(1)) : '0;
			min_index_q    <= draw_ok ? run_nxt.min_index : '0;
			max_index_q    <= draw_ok ? run_nxt.max_index : '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign range_valid  = range_valid_q;
	assign first_vertex = first_vertex_q;
	assign vertex_count = vertex_count_q;
	assign min_index    = min_index_q;
	assign max_index    = max_index_q;

	`IVRS_ASSERT_NEXT(a_last_gives_result, advance && last_s1, res_valid)
	`IVRS_ASSERT_NOW(a_valid_count_nonzero, res_valid && range_valid, vertex_count != '0)
	`IVRS_ASSERT_NOW(a_valid_index_order, res_valid && range_valid, min_index <= max_index)
	`IVRS_ASSERT_NOW(a_invalid_is_zero, res_valid && !range_valid,
		first_vertex == '0 && vertex_count == '0 && min_index == '0 && max_index == '0)

endmodule

// File: sim/index_vertex_range_scan_tb.sv
module index_vertex_range_scan_tb;
	import ivrs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic              range_valid;
		logic [DATA_W-1:0] first_vertex;
		logic [DATA_W-1:0] vertex_count;
		logic [DATA_W-1:0] min_index;
		logic [DATA_W-1:0] max_index;
	} draw_range_t;

	class draw_range_board;
		bit                short_mode;
		logic [DATA_W-1:0] base_vertex;
		logic [DATA_W-1:0] capacity;
		logic [DATA_W-1:0] low_index;
		logic [DATA_W-1:0] high_index;
		logic [DATA_W-1:0] low_vertex;
		logic [DATA_W-1:0] high_vertex;
		bit                poisoned;
		draw_range_t       expected_ranges[$];
		int                errors;

		function new();
			short_mode = 1'b1;
			base_vertex = '0;
			capacity = '0;
			errors = 0;
			start_draw();
		endfunction

		function void start_draw();
			low_index = '1;
			high_index = '0;
			low_vertex = '1;
			high_vertex = '0;
			poisoned = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] which, logic [DATA_W-1:0] value);
			case (which)
				CFG_SHORT_MODE: short_mode = value[0];
				CFG_BASE_VERTEX: base_vertex = value;
				CFG_CAPACITY: capacity = value;
				default: ;
			endcase
		endfunction

		// Called for every index transfer; a last index queues the range of its draw.
		function void take_index(logic [DATA_W-1:0] raw, logic last);
			logic [DATA_W-1:0] idx;
			logic [DATA_W-1:0] vert_bits;
			longint            vertex;
			longint            limit;
			draw_range_t       r;
			idx = raw;
			if (short_mode)
				idx[DATA_W-1:SHORT_W] = '0;
			vertex = longint'({32'd0, idx}) + longint'({{32{base_vertex[DATA_W-1]}}, base_vertex});
			limit = longint'({32'd0, capacity});
			if (vertex < 0 || vertex >= limit) begin
				poisoned = 1'b1;
			end else begin
				vert_bits = 32'(vertex);
				if (idx < low_index) low_index = idx;
				if (idx > high_index) high_index = idx;
				if (vert_bits < low_vertex) low_vertex = vert_bits;
				if (vert_bits > high_vertex) high_vertex = vert_bits;
			end
			if (!last)
				return;
			r = '0;
			if (!(poisoned || capacity == 0 || high_vertex < low_vertex)) begin
				r.range_valid = 1'b1;
				r.first_vertex = low_vertex;
				r.vertex_count = high_vertex - low_vertex + 1;
				r.min_index = low_index;
				r.max_index = high_index;
			end
			expected_ranges.push_back(r);
			start_draw();
		endfunction

		function void compare_field(string field, logic [DATA_W-1:0] want,
				logic [DATA_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h, got %h", $time, field, want, got);
			end
		endfunction

		function void check_range(draw_range_t got);
			draw_range_t want;
			if (expected_ranges.size() == 0) begin
				errors++;
				$display("%0t: result with no draw pending, got valid %b first %h count %h",
					$time, got.range_valid, got.first_vertex, got.vertex_count);
				return;
			end
			want = expected_ranges.pop_front();
			compare_field("range_valid", {31'd0, want.range_valid}, {31'd0, got.range_valid});
			compare_field("first_vertex", want.first_vertex, got.first_vertex);
			compare_field("vertex_count", want.vertex_count, got.vertex_count);
			compare_field("min_index", want.min_index, got.min_index);
			compare_field("max_index", want.max_index, got.max_index);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 idx_valid;
	logic                 idx_stall;
	logic [DATA_W-1:0]    index_value;
	logic                 last_index;
	logic                 res_valid;
	logic                 res_stall;
	logic                 range_valid;
	logic [DATA_W-1:0]    first_vertex;
	logic [DATA_W-1:0]    vertex_count;
	logic [DATA_W-1:0]    min_index;
	logic [DATA_W-1:0]    max_index;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	draw_range_board ranges;
	bit              calm;
	bit              hold_request;
	bit              result_taken;
	int              cycle_count;

	index_vertex_range_scan dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && idx_valid && !idx_stall)
			ranges.take_index(index_value, last_index);
		if (arst_n && res_valid && !res_stall) begin
			ranges.check_range({range_valid, first_vertex, vertex_count, min_index, max_index});
			result_taken = 1'b1;
		end
	end

	// The result side draws a stall length after every transfer, or holds off
	// for a long stretch when asked to.
	initial begin
		int wait_left;
		wait_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (result_taken) begin
				result_taken = 1'b0;
				wait_left = calm ? 0 : $urandom_range(0, 6);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				wait_left = HOLD_CYCLES;
			end
			res_stall = (wait_left > 0);
			if (wait_left > 0)
				wait_left--;
		end
	end

	task automatic send_index(input logic [DATA_W-1:0] value, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			idx_valid = 1'b0;
		end
		@(negedge clk);
		idx_valid = 1'b1;
		index_value = value;
		last_index = last;
		do @(posedge clk); while (idx_stall);
	endtask

	// Waits until every finished draw has produced its range and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		idx_valid = 1'b0;
		while (ranges.expected_ranges.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_index = which;
		cfg_data = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		ranges.set_reg(which, value);
	endtask

	// Mostly indices that land inside the vertex range, with edges, one past
	// the end, and some fully random values.
	function automatic logic [DATA_W-1:0] pick_index();
		logic [DATA_W-1:0] target;
		logic [DATA_W-1:0] raw;
		if (ranges.capacity == 0 || $urandom_range(0, 24) == 0)
			return $urandom();
		case ($urandom_range(0, 11))
			0: target = '0;
			1: target = ranges.capacity - 1;
			2: target = ranges.capacity;
			default: target = $urandom_range(ranges.capacity - 1, 0);
		endcase
		raw = target - ranges.base_vertex;
		if (ranges.short_mode)
			raw[DATA_W-1:SHORT_W] = 16'($urandom());
		return raw;
	endfunction

	task automatic send_draw(input int length);
		for (int i = 0; i < length; i++)
			send_index(pick_index(), i == length - 1);
	endtask

	task automatic run_phase(input bit short_mode, input logic [DATA_W-1:0] base,
			input logic [DATA_W-1:0] cap, input int items, input bit pressure, input bit quiet);
		int sent;
		int length;
		settle();
		write_reg(CFG_SHORT_MODE, short_mode ? 32'd1 : 32'd0);
		write_reg(CFG_BASE_VERTEX, base);
		write_reg(CFG_CAPACITY, cap);
		sent = 0;
		if (pressure) begin
			calm = 1'b1;
			hold_request = 1'b1;
			while (sent < 40) begin
				length = $urandom_range(1, 2);
				send_draw(length);
				sent += length;
			end
			settle();
		end
		calm = quiet;
		while (sent < items) begin
			length = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			send_draw(length);
			sent += length;
		end
		calm = 1'b0;
	endtask

	initial begin
		bit                short_mode;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] cap;
		ranges = new();
		arst_n = 1'b0;
		idx_valid = 1'b0;
		index_value = '0;
		last_index = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_SHORT_MODE;
		cfg_data = '0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero capacity straight after reset.
		send_index(32'd5, 1'b1);

		settle();
		write_reg(CFG_SHORT_MODE, 32'd0);
		write_reg(CFG_BASE_VERTEX, 32'd0);
		write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
		send_index(32'd0, 1'b0);
		send_index(32'hFFFF_FFFE, 1'b1);
		send_index(32'hFFFF_FFFF, 1'b1);
		send_index(32'd7, 1'b1);

		settle();
		write_reg(CFG_SHORT_MODE, 32'd1);
		write_reg(CFG_BASE_VERTEX, 32'hFFFF_FFFB);
		write_reg(CFG_CAPACITY, 32'd100);
		send_index(32'hABCD_0004, 1'b0);
		send_index(32'h1234_0005, 1'b1);
		send_index(32'hFFFF_0005, 1'b0);
		send_index(32'h0000_0068, 1'b0);
		send_index(32'h0010_000A, 1'b1);
		send_index(32'h0000_FFFF, 1'b1);

		settle();
		write_reg(CFG_SHORT_MODE, 32'd0);
		write_reg(CFG_BASE_VERTEX, 32'h7FFF_FFFF);
		send_index(32'd0, 1'b0);
		send_index(32'h7FFF_FFFF, 1'b1);
		send_index(32'h8000_0000, 1'b1);
		send_index(32'd10, 1'b0);

		// The base changes in the middle of a draw.
		settle();
		write_reg(CFG_BASE_VERTEX, 32'h8000_0000);
		send_index(32'hFFFF_FFFF, 1'b1);
		send_index(32'd0, 1'b1);

		// The capacity drops to zero before the last index of a draw.
		settle();
		write_reg(CFG_CAPACITY, 32'd1000);
		send_index(32'h8000_0003, 1'b0);
		settle();
		write_reg(CFG_CAPACITY, 32'd0);
		send_index(32'h8000_0004, 1'b1);

		run_phase(1'b1, 32'd0, 32'd65536, 140, 1'b0, 1'b0);
		run_phase(1'b0, 32'd0, 32'hFFFF_FFFF, 140, 1'b1, 1'b0);
		run_phase(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 130, 1'b0, 1'b1);
		run_phase(1'b0, $urandom(), 32'd0, 40, 1'b0, 1'b0);
		run_phase(1'b0, 32'd0, 32'd1, 60, 1'b0, 1'b0);
		run_phase(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 100, 1'b0, 1'b1);
		for (int p = 0; p < 5; p++) begin
			short_mode = $urandom_range(0, 1);
			if (short_mode) begin
				base = $urandom_range(0, 4000) - 2000;
				cap = $urandom_range(1, 70000);
			end else begin
				base = $urandom();
				cap = $urandom();
			end
			run_phase(short_mode, base, cap, 120, 1'b0, p == 3);
		end

		settle();
		repeat (4) @(posedge clk);
		if (ranges.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
